### rtl/core/smls_pkg.sv
// ----------------------------------------------------------------------------
// smls_pkg: shared types and constants of the spatial Moran lattice step
// Register map, command and status bundles, state codes and the division
// weight lookup used by the controller, datapath and register block.
// ----------------------------------------------------------------------------
package smls_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam int CFG_DW        = 32;
    localparam int CFG_AW        = 5;
    localparam int TOT_W         = 48;   // event rate total, fixed point
    localparam int HALF_W        = 24;   // split of the total for the draw product
    localparam int WS_W          = 18;   // sum of up to four 16-bit weights
    localparam int CNT_W         = 13;
    localparam int MAL_W         = 25;
    localparam logic [MAL_W-1:0] MAL_MAX = {MAL_W{1'b1}};
    localparam logic [15:0] ONE_Q12  = 16'd4096;
    localparam int IN_W          = 176;
    localparam int OUT_W         = 72;

    typedef enum logic [1:0] {
        KIND_REPLACE = 2'd0,
        KIND_BIRTH   = 2'd1,
        KIND_DEATH   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_DEATH_NORMAL = 3'd0,
        REG_FIT_ONE      = 3'd1,
        REG_FIT_TWO      = 3'd2,
        REG_FIT_MAL      = 3'd3,
        REG_DEATH_MAL    = 3'd4,
        REG_LIM_ZERO     = 3'd5,
        REG_LIM_ONE      = 3'd6,
        REG_LIM_TWO      = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_RDSITE,
        ST_EVAL,
        ST_NMUL,
        ST_PICK
    } state_t;

    typedef enum logic [2:0] {
        RD_C0   = 3'd0,
        RD_C1   = 3'd1,
        RD_C2   = 3'd2,
        RD_C3   = 3'd3,
        RD_SITE = 3'd4
    } rd_sel_t;

    typedef struct packed {
        logic [15:0] death_normal;
        logic [15:0] fit_one;
        logic [15:0] fit_two;
        logic [15:0] fit_mal;
        logic [15:0] death_mal;
        logic [31:0] lim_zero;
        logic [31:0] lim_one;
        logic [31:0] lim_two;
    } cfg_t;

    typedef struct packed {
        logic    load;
        logic    clr;
        logic    mul_a;
        logic    mul_b;
        logic    mul_c;
        logic    mul_d;
        logic    psum;
        logic    eval;
        logic    nmul;
        logic    commit;
        rd_sel_t rd_sel;
        logic    cap_en;
        rd_sel_t cap_sel;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } sts_t;

    function automatic logic [15:0] type_weight(input logic [1:0] t,
                                                input logic [15:0] f1,
                                                input logic [15:0] f2);
        logic [15:0] w;
        begin
            case (t)
                2'd1:    w = f1;
                2'd2:    w = f2;
                default: w = ONE_Q12;
            endcase
            return w;
        end
    endfunction

endpackage

### rtl/core/smls_cfg.sv
// ----------------------------------------------------------------------------
// smls_cfg: configuration registers
// APB-style register file holding the rates and mutation limits.
// ----------------------------------------------------------------------------
module smls_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [smls_pkg::CFG_AW-1:0] paddr,
    input  logic [smls_pkg::CFG_DW-1:0] pwdata,
    output logic [smls_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output smls_pkg::cfg_t             cfg
);
    import smls_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_DEATH_NORMAL: cfg_next.death_normal = pwdata[15:0];
                REG_FIT_ONE:      cfg_next.fit_one      = pwdata[15:0];
                REG_FIT_TWO:      cfg_next.fit_two      = pwdata[15:0];
                REG_FIT_MAL:      cfg_next.fit_mal      = pwdata[15:0];
                REG_DEATH_MAL:    cfg_next.death_mal    = pwdata[15:0];
                REG_LIM_ZERO:     cfg_next.lim_zero     = pwdata;
                REG_LIM_ONE:      cfg_next.lim_one      = pwdata;
                REG_LIM_TWO:      cfg_next.lim_two      = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEATH_NORMAL: prdata = {16'd0, cfg_reg.death_normal};
            REG_FIT_ONE:      prdata = {16'd0, cfg_reg.fit_one};
            REG_FIT_TWO:      prdata = {16'd0, cfg_reg.fit_two};
            REG_FIT_MAL:      prdata = {16'd0, cfg_reg.fit_mal};
            REG_DEATH_MAL:    prdata = {16'd0, cfg_reg.death_mal};
            REG_LIM_ZERO:     prdata = cfg_reg.lim_zero;
            REG_LIM_ONE:      prdata = cfg_reg.lim_one;
            REG_LIM_TWO:      prdata = cfg_reg.lim_two;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.death_normal <= 16'd4096;
            cfg_reg.fit_one      <= 16'd5120;
            cfg_reg.fit_two      <= 16'd5120;
            cfg_reg.fit_mal      <= 16'd6144;
            cfg_reg.death_mal    <= 16'd4096;
            cfg_reg.lim_zero     <= 32'd42949673;
            cfg_reg.lim_one      <= 32'd42949673;
            cfg_reg.lim_two      <= 32'd42949673;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/smls_ctrl.sv
// ----------------------------------------------------------------------------
// smls_ctrl: step sequencer
// Walks the lattice clearing pass and the phases of one Moran step.
// ----------------------------------------------------------------------------
module smls_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  smls_pkg::sts_t   sts,
    output smls_pkg::cmd_t   cmd
);
    import smls_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                cmd.mul_a  = 1'b1;
                cmd.rd_sel = RD_C0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_b   = 1'b1;
                cmd.rd_sel  = RD_C1;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_C0;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_c   = 1'b1;
                cmd.rd_sel  = RD_C2;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_C1;
                state_next  = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul_d   = 1'b1;
                cmd.rd_sel  = RD_C3;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_C2;
                state_next  = ST_RDSITE;
            end
            ST_RDSITE:
            begin
                cmd.psum    = 1'b1;
                cmd.rd_sel  = RD_SITE;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_C3;
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval    = 1'b1;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = RD_SITE;
                state_next  = ST_NMUL;
            end
            ST_NMUL:
            begin
                cmd.nmul   = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                // hold until the output register is free
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/core/smls_dp.sv
// ----------------------------------------------------------------------------
// smls_dp: lattice memory and step datapath
// Holds the lattice, tallies, rate products, neighbour choice and result.
// ----------------------------------------------------------------------------
module smls_dp
#(
    parameter int GRID_SIDE = smls_pkg::GRID_SIDE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  smls_pkg::cmd_t            cmd,
    output smls_pkg::sts_t            sts,
    input  smls_pkg::cfg_t            cfg,
    input  logic [smls_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [smls_pkg::OUT_W-1:0] m_tdata,
    output logic [1:0]                m_tuser
);
    import smls_pkg::*;

    localparam int SITES = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(SITES);
    localparam int RW    = $clog2(GRID_SIDE);
    localparam int TW    = $clog2(SITES + 1);

    // lattice store
    logic [1:0]    lattice_mem [SITES];
    logic [1:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;
    logic          we;
    logic [AW-1:0] clr_cnt_reg;

    // latched item
    logic [31:0]   ev_reg, nb_reg, m0_reg, m1_reg, m2_reg;
    logic [RW-1:0] row_reg, col_reg;
    logic [AW-1:0] site_reg;
    logic [8:0]    row_x, col_x, row_c, col_c;
    logic [AW-1:0] site_in;

    // rate arithmetic
    logic [TOT_W-1:0]    dn_reg, birth_reg, malsum_reg, total_reg, pos_reg;
    logic [55:0]         prod_lo_reg, prod_hi_reg;
    logic [79:0]         prod_sum;
    logic [16:0]         rate_sum;
    logic [40:0]         birth_p;
    logic [41:0]         malsum_p;
    logic [WS_W-1:0]     wsum_reg, npos_reg;
    logic [WS_W+31:0]    nprod;
    kind_t               kind_reg;
    logic                mut0_reg, mut1_reg, mut2_reg;

    // neighbours
    logic [AW-1:0]   raw [4];
    logic [3:0]      ok, uniq;
    logic [1:0]      types_reg [5];
    logic [WS_W-1:0] w [4];
    logic [WS_W-1:0] cum [4];

    // tallies
    logic [TW-1:0]    tn_reg, t1_reg, t2_reg, tn_next, t1_next, t2_next;
    logic [MAL_W-1:0] tm_reg, tm_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    logic [1:0]       out_user_reg;

    logic [1:0] par_t, old_t, new_t, site_after;
    logic       found, mal_inc, mal_dec, change;

    assign sts.clr_last = (clr_cnt_reg == AW'(SITES - 1));
    assign sts.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_user_reg;

    // clamp the site onto the grid
    always_comb
    begin
        row_x   = {3'd0, s_tdata[165:160]};
        col_x   = {3'd0, s_tdata[171:166]};
        row_c   = (row_x > 9'(GRID_SIDE - 1)) ? 9'(GRID_SIDE - 1) : row_x;
        col_c   = (col_x > 9'(GRID_SIDE - 1)) ? 9'(GRID_SIDE - 1) : col_x;
        site_in = AW'(row_c) * AW'(GRID_SIDE) + AW'(col_c);
    end

    // candidate neighbours, out-of-grid and repeated ones dropped
    always_comb
    begin
        raw[0]  = (col_reg == RW'(GRID_SIDE - 1)) ? site_reg - AW'(1) : site_reg + AW'(1);
        raw[1]  = (row_reg == '0) ? site_reg + AW'(GRID_SIDE) : site_reg - AW'(GRID_SIDE);
        raw[2]  = site_reg - AW'(1);
        raw[3]  = site_reg + AW'(GRID_SIDE);
        ok[0]   = 1'b1;
        ok[1]   = 1'b1;
        ok[2]   = (col_reg != '0);
        ok[3]   = (row_reg != RW'(GRID_SIDE - 1));
        uniq[0] = 1'b1;
        uniq[1] = (raw[1] != raw[0]);
        uniq[2] = ok[2] && (raw[2] != raw[0]) && !(uniq[1] && raw[2] == raw[1]);
        uniq[3] = ok[3] && (raw[3] != raw[0]) && !(uniq[1] && raw[3] == raw[1])
                  && !(uniq[2] && raw[3] == raw[2]);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_C0:   rd_addr = raw[0];
            RD_C1:   rd_addr = raw[1];
            RD_C2:   rd_addr = ok[2] ? raw[2] : site_reg;
            RD_C3:   rd_addr = ok[3] ? raw[3] : site_reg;
            RD_SITE: rd_addr = site_reg;
            default: rd_addr = site_reg;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            w[k] = uniq[k] ? WS_W'(type_weight(types_reg[k], cfg.fit_one, cfg.fit_two)) : '0;
        cum[0] = w[0];
        for (int k = 1; k < 4; k++)
            cum[k] = cum[k-1] + w[k];
    end

    assign rate_sum = {1'b0, cfg.fit_mal} + {1'b0, cfg.death_mal};
    assign birth_p  = cfg.fit_mal * tm_reg;
    assign malsum_p = rate_sum * tm_reg;
    assign prod_sum = {prod_hi_reg, {HALF_W{1'b0}}} + 80'(prod_lo_reg);
    assign nprod    = nb_reg * wsum_reg;

    // parent choice, mutation and tally update
    always_comb
    begin
        par_t = uniq[3] ? types_reg[3] : uniq[2] ? types_reg[2] :
                uniq[1] ? types_reg[1] : types_reg[0];
        found = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!found && uniq[k] && (npos_reg < cum[k]))
            begin
                par_t = types_reg[k];
                found = 1'b1;
            end
        end
        old_t   = types_reg[4];
        new_t   = old_t;
        mal_inc = 1'b0;
        mal_dec = 1'b0;
        case (kind_reg)
            KIND_REPLACE:
            begin
                case (par_t)
                    2'd0:    new_t = mut0_reg ? 2'd1 : 2'd0;
                    2'd1:    new_t = mut1_reg ? 2'd2 : 2'd1;
                    2'd2:
                    begin
                        if (mut2_reg)
                            mal_inc = 1'b1;
                        else
                            new_t = 2'd2;
                    end
                    default: new_t = old_t;
                endcase
            end
            KIND_BIRTH: mal_inc = 1'b1;
            KIND_DEATH: mal_dec = 1'b1;
            default:    mal_dec = 1'b0;
        endcase
        change     = (kind_reg == KIND_REPLACE) && (new_t != old_t);
        site_after = (kind_reg == KIND_REPLACE) ? new_t : old_t;

        tn_next = tn_reg;
        t1_next = t1_reg;
        t2_next = t2_reg;
        tm_next = tm_reg;
        if (cmd.commit)
        begin
            if (change)
            begin
                if (old_t == 2'd0 && tn_reg != '0) tn_next = tn_reg - TW'(1);
                if (old_t == 2'd1 && t1_reg != '0) t1_next = t1_reg - TW'(1);
                if (old_t == 2'd2 && t2_reg != '0) t2_next = t2_reg - TW'(1);
                if (new_t == 2'd0) tn_next = tn_reg + TW'(1);
                if (new_t == 2'd1) t1_next = t1_reg + TW'(1);
                if (new_t == 2'd2) t2_next = t2_reg + TW'(1);
            end
            if (mal_inc && tm_reg != MAL_MAX)
                tm_next = tm_reg + MAL_W'(1);
            if (mal_dec && tm_reg != '0)
                tm_next = tm_reg - MAL_W'(1);
        end

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign we      = cmd.clr || (cmd.commit && change);
    assign wr_addr = cmd.clr ? clr_cnt_reg : site_reg;
    assign wr_data = cmd.clr ? 2'd0 : new_t;

    always_ff @(posedge clk)
    begin
        if (we)
            lattice_mem[wr_addr] <= wr_data;
        rd_data_reg <= lattice_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ev_reg   <= s_tdata[31:0];
            nb_reg   <= s_tdata[63:32];
            m0_reg   <= s_tdata[95:64];
            m1_reg   <= s_tdata[127:96];
            m2_reg   <= s_tdata[159:128];
            row_reg  <= RW'(row_c);
            col_reg  <= RW'(col_c);
            site_reg <= site_in;
        end
        if (cmd.mul_a)
        begin
            dn_reg     <= TOT_W'(cfg.death_normal) * TOT_W'(SITES);
            birth_reg  <= TOT_W'(birth_p);
            malsum_reg <= TOT_W'(malsum_p);
        end
        if (cmd.mul_b)
            total_reg <= dn_reg + malsum_reg;
        if (cmd.mul_c)
            prod_lo_reg <= ev_reg * total_reg[HALF_W-1:0];
        if (cmd.mul_d)
            prod_hi_reg <= ev_reg * total_reg[TOT_W-1:HALF_W];
        if (cmd.psum)
            pos_reg <= prod_sum[79:32];
        if (cmd.cap_en)
        begin
            case (cmd.cap_sel)
                RD_C0:   types_reg[0] <= rd_data_reg;
                RD_C1:   types_reg[1] <= rd_data_reg;
                RD_C2:   types_reg[2] <= rd_data_reg;
                RD_C3:   types_reg[3] <= rd_data_reg;
                RD_SITE: types_reg[4] <= rd_data_reg;
                default: types_reg[4] <= rd_data_reg;
            endcase
        end
        if (cmd.eval)
        begin
            if (pos_reg < dn_reg)
                kind_reg <= KIND_REPLACE;
            else if (pos_reg < dn_reg + birth_reg)
                kind_reg <= KIND_BIRTH;
            else
                kind_reg <= KIND_DEATH;
            wsum_reg <= cum[3];
            mut0_reg <= (m0_reg < cfg.lim_zero);
            mut1_reg <= (m1_reg < cfg.lim_one);
            mut2_reg <= (m2_reg < cfg.lim_two);
        end
        if (cmd.nmul)
            npos_reg <= nprod[WS_W+31:32];
        if (cmd.commit)
        begin
            out_data_reg <= {6'd0, site_after, tm_next, CNT_W'(t2_next),
                             CNT_W'(t1_next), CNT_W'(tn_next)};
            out_user_reg <= kind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            tn_reg        <= TW'(SITES);
            t1_reg        <= '0;
            t2_reg        <= '0;
            tm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            tn_reg        <= tn_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
            tm_reg        <= tm_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/spatial_moran_lattice_step.sv
// ----------------------------------------------------------------------------
// spatial_moran_lattice_step: one stochastic Moran step per item
// Lattice of GRID_SIDE x GRID_SIDE sites plus an off-grid malignant count.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | draws and site: tdata, one beat per step
//  m_*     | out       | tallies, site type (tdata), event kind (tuser)
//  p*      | in/out    | APB-style register access, eight registers
//
//  The result beat is registered when the step commits, and a new input beat
//  is taken only once the previous step has committed. Each step works
//  through five lattice reads on the single read port, two 32x24
//  partial products of the event draw multiply, the weight sum and the
//  neighbour multiply.
//  After reset the lattice is zeroed by a sweep over all GRID_SIDE*GRID_SIDE
//  sites (4096 at the default size) during which s_tready stays low.
//  A result waiting on m_tready does not block the next input beat; the
//  step only holds in its final cycle until the output register frees.
// ----------------------------------------------------------------------------
module spatial_moran_lattice_step
#(
    parameter int GRID_SIDE = smls_pkg::GRID_SIDE_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // event_draw, neighbour_draw, mut_draw_zero, mut_draw_one,
    // mut_draw_two, site_row, site_col (lowest bit up)
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [smls_pkg::IN_W-1:0]    s_tdata,
    // count_normal, count_first_hit, count_premalignant, count_malignant,
    // site_type_after (lowest bit up)
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [smls_pkg::OUT_W-1:0]   m_tdata,
    // event_kind
    output logic [1:0]                   m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [smls_pkg::CFG_AW-1:0]  paddr,
    input  logic [smls_pkg::CFG_DW-1:0]  pwdata,
    output logic [smls_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import smls_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    smls_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: owns the input handshake and the step phases
    smls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: lattice memory, rate products, tallies and the result beat
    smls_dp #(.GRID_SIDE(GRID_SIDE)) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // the clearing sweep never overlaps an input beat
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |-> !s_tready)
        else $error("input ready during lattice clear");

    // a step never overwrites a result still waiting downstream
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("commit into a busy output register");

    // every result beat comes from a commit
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result beat without a committed step");

    // one step at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second input beat taken during a step");

endmodule

### tb/moran_checker.sv
// ----------------------------------------------------------------------------
// moran_checker: predicts and checks each Moran step result
// Tracks register writes on the APB port, keeps its own lattice and tallies,
// queues the expected result for every accepted input beat and compares
// every output beat against the oldest entry.
// ----------------------------------------------------------------------------
module moran_checker
    import smls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [CFG_DW-1:0]    pwdata,
    input  logic                 pready,
    output int                   fail_count,
    output int                   pending
);

    localparam int SIDE  = GRID_SIDE_DEF;
    localparam int SITES = SIDE * SIDE;

    typedef struct packed {
        logic [CNT_W-1:0] cnt_normal;
        logic [CNT_W-1:0] cnt_one;
        logic [CNT_W-1:0] cnt_two;
        logic [MAL_W-1:0] cnt_mal;
        kind_t            kind;
        logic [1:0]       site_type;
    } step_res_t;

    step_res_t   step_q[$];
    cfg_t        cfg;
    logic [1:0]  lat [SITES];
    logic [31:0] n_normal, n_one, n_two, n_mal;

    // floor(frac * x / 2^32), exact
    function automatic logic [63:0] frac_of(logic [31:0] frac, logic [63:0] x);
        logic [95:0] p;
        p = {64'd0, frac} * {32'd0, x};
        return p[95:32];
    endfunction

    function automatic logic [63:0] weight_of(logic [1:0] t);
        if (t == 2'd1) return {48'd0, cfg.fit_one};
        if (t == 2'd2) return {48'd0, cfg.fit_two};
        return {48'd0, ONE_Q12};
    endfunction

    function automatic void tally_move(logic [1:0] t, bit up);
        if (t == 2'd1)      n_one    = up ? n_one + 1    : (n_one > 0 ? n_one - 1 : 0);
        else if (t == 2'd2) n_two    = up ? n_two + 1    : (n_two > 0 ? n_two - 1 : 0);
        else                n_normal = up ? n_normal + 1 : (n_normal > 0 ? n_normal - 1 : 0);
    endfunction

    function automatic step_res_t moran_step(logic [IN_W-1:0] d);
        logic [31:0] ev, nb, m0, m1, m2;
        int          r, c, site, n, parent;
        int          raw [4];
        bit          ok [4];
        int          cand [4];
        bit          dup;
        logic [63:0] dn, birth, total, pos, wsum, npos, cum;
        logic [1:0]  pt, old, nt;
        kind_t       kind;
        step_res_t   res;
        ev = d[31:0];    nb = d[63:32];   m0 = d[95:64];
        m1 = d[127:96];  m2 = d[159:128];
        r  = d[165:160]; c  = d[171:166];
        if (r > SIDE - 1) r = SIDE - 1;
        if (c > SIDE - 1) c = SIDE - 1;
        site  = r * SIDE + c;
        dn    = 64'(cfg.death_normal) * SITES;
        birth = 64'(cfg.fit_mal) * n_mal;
        total = dn + birth + 64'(cfg.death_mal) * n_mal;
        pos   = frac_of(ev, total);
        if (pos < dn) begin
            raw[0] = (c == SIDE - 1) ? site - 1 : site + 1;    ok[0] = 1;
            raw[1] = (r == 0) ? site + SIDE : site - SIDE;    ok[1] = 1;
            raw[2] = site - 1;                                ok[2] = (c > 0);
            raw[3] = site + SIDE;                             ok[3] = (r < SIDE - 1);
            n = 0;
            for (int k = 0; k < 4; k++) begin
                if (ok[k]) begin
                    dup = 0;
                    for (int q = 0; q < n; q++) if (cand[q] == raw[k]) dup = 1;
                    if (!dup) begin
                        cand[n] = raw[k];
                        n++;
                    end
                end
            end
            wsum = 0;
            for (int k = 0; k < n; k++) wsum += weight_of(lat[cand[k]]);
            npos   = frac_of(nb, wsum);
            cum    = 0;
            parent = cand[n-1];
            for (int k = 0; k < n; k++) begin
                cum += weight_of(lat[cand[k]]);
                if (npos < cum) begin
                    parent = cand[k];
                    break;
                end
            end
            pt  = lat[parent];
            old = lat[site];
            nt  = old;
            if (pt == 2'd0)      nt = (m0 < cfg.lim_zero) ? 2'd1 : 2'd0;
            else if (pt == 2'd1) nt = (m1 < cfg.lim_one) ? 2'd2 : 2'd1;
            else if (pt == 2'd2) begin
                if (m2 < cfg.lim_two) begin
                    if (n_mal < MAL_MAX) n_mal++;
                end
                else nt = 2'd2;
            end
            if (nt != old) begin
                tally_move(old, 0);
                tally_move(nt, 1);
                lat[site] = nt;
            end
            kind = KIND_REPLACE;
        end
        else if (pos < dn + birth) begin
            if (n_mal < MAL_MAX) n_mal++;
            kind = KIND_BIRTH;
        end
        else begin
            if (n_mal > 0) n_mal--;
            kind = KIND_DEATH;
        end
        res.cnt_normal = n_normal[CNT_W-1:0];
        res.cnt_one    = n_one[CNT_W-1:0];
        res.cnt_two    = n_two[CNT_W-1:0];
        res.cnt_mal    = n_mal[MAL_W-1:0];
        res.kind       = kind;
        res.site_type  = lat[site];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_res_t exp_r;
        step_res_t got;
        if (!rst_n)
        begin
            cfg.death_normal = 16'd4096;
            cfg.fit_one      = 16'd5120;
            cfg.fit_two      = 16'd5120;
            cfg.fit_mal      = 16'd6144;
            cfg.death_mal    = 16'd4096;
            cfg.lim_zero     = 32'd42949673;
            cfg.lim_one      = 32'd42949673;
            cfg.lim_two      = 32'd42949673;
            foreach (lat[i]) lat[i] = 2'd0;
            n_normal = SITES;
            n_one    = 0;
            n_two    = 0;
            n_mal    = 0;
            step_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[CFG_AW-1:2]))
                    REG_DEATH_NORMAL: cfg.death_normal = pwdata[15:0];
                    REG_FIT_ONE:      cfg.fit_one      = pwdata[15:0];
                    REG_FIT_TWO:      cfg.fit_two      = pwdata[15:0];
                    REG_FIT_MAL:      cfg.fit_mal      = pwdata[15:0];
                    REG_DEATH_MAL:    cfg.death_mal    = pwdata[15:0];
                    REG_LIM_ZERO:     cfg.lim_zero     = pwdata;
                    REG_LIM_ONE:      cfg.lim_one      = pwdata;
                    REG_LIM_TWO:      cfg.lim_two      = pwdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.cnt_normal = m_tdata[12:0];
                got.cnt_one    = m_tdata[25:13];
                got.cnt_two    = m_tdata[38:26];
                got.cnt_mal    = m_tdata[63:39];
                got.site_type  = m_tdata[65:64];
                got.kind       = kind_t'(m_tuser);
                if (step_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: %p", got);
                end
                else
                begin
                    exp_r = step_q.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p, got %p", exp_r, got);
                    end
                end
            end
            // predict after the output check so an accepted input this cycle queues behind
            if (s_tvalid && s_tready)
                step_q.push_back(moran_step(s_tdata));
            pending = step_q.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the spatial Moran lattice step
// Drives draw beats and register writes through several idling phases,
// while the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import smls_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;  // event, neighbour, mut0..2 draws, row, col
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;       // tallies 0..2, malignant, site type
    logic [1:0]          m_tuser;       // event kind
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;

    // idling percentages for the current phase
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    spatial_moran_lattice_step dut (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    moran_checker chk (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fail_count, .pending
    );

    // receiver: stall at random by the phase percentage
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // hard stop well beyond the slowest correct run
    initial
    begin
        #40000000;
        $display("FAIL spatial_moran_lattice_step");
        $finish;
    end

    // drop valid, wait for every queued result, then let the pipeline drain
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // setup phase then access phase, then psel drops before the task returns
    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(logic [15:0] dn, logic [15:0] f1, logic [15:0] f2,
                           logic [15:0] fm, logic [15:0] dm,
                           logic [31:0] l0, logic [31:0] l1, logic [31:0] l2);
        drain();
        reg_write(REG_DEATH_NORMAL, {16'd0, dn});
        reg_write(REG_FIT_ONE,      {16'd0, f1});
        reg_write(REG_FIT_TWO,      {16'd0, f2});
        reg_write(REG_FIT_MAL,      {16'd0, fm});
        reg_write(REG_DEATH_MAL,    {16'd0, dm});
        reg_write(REG_LIM_ZERO,     l0);
        reg_write(REG_LIM_ONE,      l1);
        reg_write(REG_LIM_TWO,      l2);
    endtask

    // one beat; valid stays high between back-to-back beats
    task automatic send_step(logic [31:0] ev, logic [31:0] nb, logic [31:0] m0,
                             logic [31:0] m1, logic [31:0] m2,
                             logic [5:0] row, logic [5:0] col);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, col, row, m2, m1, m0, nb, ev};
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [31:0] draw32();
        case ($urandom_range(15))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly a small corner patch so cell types build up, sometimes anywhere
    task automatic send_random();
        logic [5:0] row, col;
        if ($urandom_range(99) < 75)
        begin
            row = 6'($urandom_range(3));
            col = 6'($urandom_range(3));
        end
        else
        begin
            row = 6'($urandom_range(63));
            col = 6'($urandom_range(63));
        end
        send_step(draw32(), draw32(), draw32(), draw32(), draw32(), row, col);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners and edges, extreme draws, default registers
        send_step(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 6'd0, 6'd0);
        send_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 6'd63, 6'd63);
        send_step(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 6'd0, 6'd63);
        send_step(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 6'd63, 6'd0);

        // directed: certain mutation, push a small patch to type 2 then malignant
        set_all(16'd4096, 16'd5120, 16'd5120, 16'd6144, 16'd4096,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            send_step(32'd0, $urandom, 32'd0, 32'd0, 32'hFFFF_FFFF,
                      6'($urandom_range(1)), 6'($urandom_range(1)));
        for (int i = 0; i < 3; i++)
            send_step(32'd0, $urandom, 32'd0, 32'd0, 32'd0, 6'd0, 6'd0);
        // a death step once malignant cells exist
        send_step(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 6'd5, 6'd5);

        // zero total rate: death, and death at a malignant count of zero
        set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 4; i++)
            send_step($urandom, $urandom, $urandom, $urandom, $urandom, 6'd1, 6'd1);
        // zero weights: last candidate divides
        set_all(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        send_step(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 6'd0, 6'd1);

        // random phases, cycling the four idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_all(16'd4096, 16'd5120, 16'd5120, 16'd6144, 16'd4096,
                           32'h4000_0000, 32'h4000_0000, 32'h2000_0000);
                1: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_all(16'd64, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                           32'h8000_0000, 32'd0, 32'h8000_0000);
                3: set_all(16'd0, 16'd5120, 16'd5120, 16'hFFFF, 16'd1,
                           32'd0, 32'd0, 32'd0);
                default: set_all(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom),
                                 $urandom, $urandom, $urandom);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int i = 0; i < 190; i++)
            begin
                // hold off once mid-phase until every result is back
                if (ph == 4 && i == 95)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
                send_random();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        drain();
        if (fail_count == 0)
            $display("PASS spatial_moran_lattice_step");
        else
            $display("FAIL spatial_moran_lattice_step");
        $finish;
    end

endmodule

### spatial_moran_lattice_step.f
rtl/core/smls_pkg.sv
rtl/core/smls_cfg.sv
rtl/core/smls_ctrl.sv
rtl/core/smls_dp.sv
rtl/core/spatial_moran_lattice_step.sv
tb/moran_checker.sv
tb/tb.sv
